// ===== sv/vtp_pkg.sv =====
// Shared types and constants for the vertex transform and projection pipeline.
package vtp_pkg;

    localparam int CAM_W  = 19;
    localparam int NUM_W  = 34;
    localparam int MAG_W  = 33;
    localparam int DEN_W  = 20;
    localparam int QUO_W  = 16;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZNEG = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [2:0] REG_COL_X  = 3'd0;
    localparam logic [2:0] REG_COL_Y  = 3'd1;
    localparam logic [2:0] REG_COL_Z  = 3'd2;
    localparam logic [2:0] REG_VIEW_W = 3'd3;
    localparam logic [2:0] REG_VIEW_H = 3'd4;

    localparam logic [63:0] RST_COL_X  = 64'h0000_0000_0000_4000;
    localparam logic [63:0] RST_COL_Y  = 64'h0000_0000_4000_0000;
    localparam logic [63:0] RST_COL_Z  = 64'h0000_4000_0000_0000;
    localparam logic [12:0] RST_VIEW_W = 13'd800;
    localparam logic [12:0] RST_VIEW_H = 13'd600;

    typedef struct packed {
        logic [63:0] col_x;
        logic [63:0] col_y;
        logic [63:0] col_z;
        logic [12:0] view_w;
        logic [12:0] view_h;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic               last;
    } t_vtx;

    typedef struct packed {
        logic signed [CAM_W-1:0] cx;
        logic signed [CAM_W-1:0] cy;
        logic signed [CAM_W-1:0] cz;
        logic                    last;
    } t_cam;

    // one divider lane: partial remainder, quotient bits, sign, overflow
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        t_lane                   lx;
        t_lane                   ly;
        logic [DEN_W-1:0]        den;
        logic signed [CAM_W-1:0] cz;
        logic                    last;
    } t_divw;

endpackage

// ===== sv/vtp_xform.sv =====
// Affine 4x3 matrix transform: model-space vertex to rounded Q11.8 camera space.
module vtp_xform import vtp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_vtx i_data,
    input  t_cfg i_cfg,
    output logic o_valid,
    input  logic i_ready,
    output t_cam o_data
);

    logic [63:0]        w_col [3];
    logic signed [15:0] w_v [3];
    logic signed [31:0] n_prod [3][3];
    logic signed [31:0] r_prod [3][3];
    logic signed [15:0] r_trans [3];
    logic               r_last1;
    logic               r_vld1;
    logic signed [33:0] w_acc [3];
    logic signed [CAM_W-1:0] n_c [3];
    t_cam               r_cam;
    logic               r_vld2;
    logic               w_rdy1;
    logic               w_rdy2;

    assign w_col[0] = i_cfg.col_x;
    assign w_col[1] = i_cfg.col_y;
    assign w_col[2] = i_cfg.col_z;
    assign w_v[0]   = i_data.vx;
    assign w_v[1]   = i_data.vy;
    assign w_v[2]   = i_data.vz;

    assign w_rdy2  = !r_vld2 || i_ready;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_cam;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[a][k] = w_v[k] * $signed(w_col[a][16*k +: 16]);
            end
        end
    end

    // Q.22 sum, round half up, floor back to Q11.8
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_acc[a] = 34'(r_prod[a][0]) + 34'(r_prod[a][1]) + 34'(r_prod[a][2])
                     + (34'(r_trans[a]) <<< 14) + 34'sd8192;
            n_c[a]   = w_acc[a][32:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_prod  <= n_prod;
            r_last1 <= i_data.last;
            for (int a = 0; a < 3; a++) begin
                r_trans[a] <= $signed(w_col[a][63:48]);
            end
        end
        if (w_rdy2 && r_vld1) begin
            r_cam.cx   <= n_c[0];
            r_cam.cy   <= n_c[1];
            r_cam.cz   <= n_c[2];
            r_cam.last <= r_last1;
        end
    end

endmodule

// ===== sv/vtp_numer.sv =====
// Projection numerators and denominator, sign/magnitude split, quotient overflow check.
module vtp_numer import vtp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cam i_data,
    input  t_cfg i_cfg,
    output logic o_valid,
    input  logic i_ready,
    output t_divw o_data
);

    logic signed [13:0]       w_h;
    logic signed [13:0]       w_w;
    logic signed [DEN_W-1:0]  w_d;
    logic signed [NUM_W-1:0]  n_prod_x;
    logic signed [NUM_W-1:0]  n_wcz;
    logic signed [NUM_W-1:0]  n_prod_y;

    logic                     r_vld_c;
    logic signed [NUM_W-1:0]  r_prod_x;
    logic signed [NUM_W-1:0]  r_wcz;
    logic signed [NUM_W-1:0]  r_prod_y;
    logic [DEN_W-1:0]         r_den_c;
    logic signed [CAM_W-1:0]  r_cz_c;
    logic                     r_last_c;

    logic signed [NUM_W-1:0]  w_num_x;
    t_lane                    n_lx;
    t_lane                    n_ly;

    logic                     r_vld_d;
    t_lane                    r_lx;
    t_lane                    r_ly;
    logic [DEN_W-1:0]         r_den_d;
    logic signed [CAM_W-1:0]  r_cz_d;
    logic                     r_last_d;

    logic [DEN_W+QUO_W-1:0]   w_lim;
    t_divw                    n_out;
    t_divw                    r_out;
    logic                     r_vld_e;

    logic                     w_rdy_c;
    logic                     w_rdy_d;
    logic                     w_rdy_e;

    assign w_rdy_e = !r_vld_e || i_ready;
    assign w_rdy_d = !r_vld_d || w_rdy_e;
    assign w_rdy_c = !r_vld_c || w_rdy_d;
    assign o_ready = w_rdy_c;
    assign o_valid = r_vld_e;
    assign o_data  = r_out;

    // x numerator: cx*H + W*cz ; y numerator: H*(cz - cy) ; denominator 2*cz
    assign w_h      = $signed({1'b0, i_cfg.view_h});
    assign w_w      = $signed({1'b0, i_cfg.view_w});
    assign w_d      = DEN_W'($signed(i_data.cz)) - DEN_W'($signed(i_data.cy));
    assign n_prod_x = $signed(i_data.cx) * w_h;
    assign n_wcz    = $signed(i_data.cz) * w_w;
    assign n_prod_y = w_d * w_h;

    assign w_num_x = r_prod_x + r_wcz;

    always_comb begin
        n_lx     = '0;
        n_ly     = '0;
        n_lx.neg = w_num_x[NUM_W-1];
        n_ly.neg = r_prod_y[NUM_W-1];
        n_lx.rem = n_lx.neg ? MAG_W'(-w_num_x) : MAG_W'(w_num_x);
        n_ly.rem = n_ly.neg ? MAG_W'(-r_prod_y) : MAG_W'(r_prod_y);
    end

    // quotient of 2^16 or more cannot fit the divider
    assign w_lim = {r_den_d, {QUO_W{1'b0}}};

    always_comb begin
        n_out        = '0;
        n_out.lx     = r_lx;
        n_out.ly     = r_ly;
        n_out.lx.ovf = (DEN_W+QUO_W)'(r_lx.rem) >= w_lim;
        n_out.ly.ovf = (DEN_W+QUO_W)'(r_ly.rem) >= w_lim;
        n_out.den    = r_den_d;
        n_out.cz     = r_cz_d;
        n_out.last   = r_last_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            if (w_rdy_c) r_vld_c <= i_valid;
            if (w_rdy_d) r_vld_d <= r_vld_c;
            if (w_rdy_e) r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && i_valid) begin
            r_prod_x <= n_prod_x;
            r_wcz    <= n_wcz;
            r_prod_y <= n_prod_y;
            r_den_c  <= {i_data.cz[CAM_W-1:0], 1'b0};
            r_cz_c   <= i_data.cz;
            r_last_c <= i_data.last;
        end
        if (w_rdy_d && r_vld_c) begin
            r_lx     <= n_lx;
            r_ly     <= n_ly;
            r_den_d  <= r_den_c;
            r_cz_d   <= r_cz_c;
            r_last_d <= r_last_c;
        end
        if (w_rdy_e && r_vld_d) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/vtp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a denominator.
module vtp_div import vtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_divw i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_divw o_data
);

    logic [DIV_STAGES-1:0] r_vld;
    t_divw                 r_stg [DIV_STAGES];
    logic [DIV_STAGES:0]   w_rdy;

    function automatic t_lane f_step(input t_lane l, input logic [DEN_W-1:0] den,
                                     input logic [3:0] sh);
        logic [DEN_W+QUO_W-1:0] trial;
        t_lane                  res;
        res   = l;
        trial = (DEN_W+QUO_W)'(den) << sh;
        if ((DEN_W+QUO_W)'(l.rem) >= trial) begin
            res.rem     = l.rem - trial[MAG_W-1:0];
            res.quo[sh] = 1'b1;
        end
        return res;
    endfunction

    assign w_rdy[DIV_STAGES] = i_ready;
    assign o_ready           = w_rdy[0];
    assign o_valid           = r_vld[DIV_STAGES-1];
    assign o_data            = r_stg[DIV_STAGES-1];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_divw w_in;
        logic  w_vin;
        t_divw n_stg;

        if (s == 0) begin : g_first
            assign w_in  = i_data;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_stg[s-1];
            assign w_vin = r_vld[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_comb begin
            n_stg    = w_in;
            n_stg.lx = f_step(w_in.lx, w_in.den, 4'(DIV_STAGES-1-s));
            n_stg.ly = f_step(w_in.ly, w_in.den, 4'(DIV_STAGES-1-s));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_vin) begin
                r_stg[s] <= n_stg;
            end
        end
    end

endmodule

// ===== sv/vertex_transform_project.sv =====
// Top level: vertex transform and perspective projection with config registers.
//
// Transforms one Q8.8 vertex per clock through the packed affine matrix, divides camera
// x and y by camera z and maps to viewport pixels truncated toward zero. The pipeline
// registers the matrix multiply and rounding, then the numerators and overflow check,
// then the divider stages (one quotient bit per stage) and last the saturating output
// register. A new word is accepted every cycle; a stalled output only holds back the
// stages behind it once they fill. status in m_axis_tuser is 0 ok, 1 depth not
// positive (pixels forced to 0), 2 pixel saturated. Config writes take effect on the
// next edge and must only be issued while the pipeline is empty.
module vertex_transform_project import vtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // screen_x, screen_y, depth, zero pad
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_col_x;
    logic [63:0] r_col_y;
    logic [63:0] r_col_z;
    logic [12:0] r_view_w;
    logic [12:0] r_view_h;
    t_cfg        w_cfg;

    t_vtx        w_vtx;
    logic        w_xf_vld;
    logic        w_xf_rdy;
    t_cam        w_cam;
    logic        w_nm_vld;
    logic        w_nm_rdy;
    t_divw       w_nm;
    logic        w_dv_vld;
    logic        w_dv_rdy;
    t_divw       w_dv;

    logic [16:0] w_cx;
    logic [16:0] w_cy;
    logic        w_zneg;
    logic [15:0] n_sx;
    logic [15:0] n_sy;
    logic [1:0]  n_status;

    logic               r_m_vld;
    logic [15:0]        r_sx;
    logic [15:0]        r_sy;
    logic [CAM_W-1:0]   r_depth;
    logic [1:0]         r_status;
    logic               r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_x  <= RST_COL_X;
            r_col_y  <= RST_COL_Y;
            r_col_z  <= RST_COL_Z;
            r_view_w <= RST_VIEW_W;
            r_view_h <= RST_VIEW_H;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COL_X:  r_col_x  <= i_cfg_data;
                REG_COL_Y:  r_col_y  <= i_cfg_data;
                REG_COL_Z:  r_col_z  <= i_cfg_data;
                REG_VIEW_W: r_view_w <= i_cfg_data[12:0];
                REG_VIEW_H: r_view_h <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.col_x  = r_col_x;
    assign w_cfg.col_y  = r_col_y;
    assign w_cfg.col_z  = r_col_z;
    assign w_cfg.view_w = r_view_w;
    assign w_cfg.view_h = r_view_h;

    assign w_vtx.vx   = s_axis_tdata[15:0];
    assign w_vtx.vy   = s_axis_tdata[31:16];
    assign w_vtx.vz   = s_axis_tdata[47:32];
    assign w_vtx.last = s_axis_tlast;

    vtp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_vtx),
        .i_cfg   (w_cfg),
        .o_valid (w_xf_vld),
        .i_ready (w_xf_rdy),
        .o_data  (w_cam)
    );

    vtp_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xf_vld),
        .o_ready (w_xf_rdy),
        .i_data  (w_cam),
        .i_cfg   (w_cfg),
        .o_valid (w_nm_vld),
        .i_ready (w_nm_rdy),
        .o_data  (w_nm)
    );

    vtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nm_vld),
        .o_ready (w_nm_rdy),
        .i_data  (w_nm),
        .o_valid (w_dv_vld),
        .i_ready (w_dv_rdy),
        .o_data  (w_dv)
    );

    // {sat, value}: apply sign to the truncated magnitude and clamp to 16 bits
    function automatic logic [16:0] f_clamp(input t_lane l);
        logic        sat;
        logic [15:0] v;
        sat = 1'b0;
        v   = l.quo;
        if (l.ovf) begin
            sat = 1'b1;
            v   = l.neg ? 16'h8000 : 16'h7FFF;
        end else if (l.neg) begin
            if (l.quo > 16'd32768) begin
                sat = 1'b1;
                v   = 16'h8000;
            end else begin
                v = 16'(-l.quo);
            end
        end else if (l.quo > 16'd32767) begin
            sat = 1'b1;
            v   = 16'h7FFF;
        end
        return {sat, v};
    endfunction

    assign w_cx   = f_clamp(w_dv.lx);
    assign w_cy   = f_clamp(w_dv.ly);
    assign w_zneg = !($signed(w_dv.cz) > 0);

    always_comb begin
        n_sx     = w_cx[15:0];
        n_sy     = w_cy[15:0];
        n_status = ST_OK;
        if (w_zneg) begin
            n_sx     = '0;
            n_sy     = '0;
            n_status = ST_ZNEG;
        end else if (w_cx[16] || w_cy[16]) begin
            n_status = ST_SAT;
        end
    end

    assign w_dv_rdy = !r_m_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_dv_rdy) begin
            r_m_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_rdy && w_dv_vld) begin
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_depth  <= w_dv.cz;
            r_status <= n_status;
            r_last   <= w_dv.last;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = {5'b0, r_depth, r_sy, r_sx};
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;

endmodule

// ===== sv/vtp_checker.sv =====
// Port-level checks for the vertex transform and projection block, bound to the top level.
module vtp_checker import vtp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    a_zneg_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ST_ZNEG)
            == (m_axis_tdata[50] || (m_axis_tdata[50:32] == 19'd0))))
        else $error("status does not match depth sign");

    a_zneg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_ZNEG) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("non-positive depth with nonzero pixels");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_SAT) |->
            (m_axis_tdata[15:0] == 16'h7FFF) || (m_axis_tdata[15:0] == 16'h8000)
            || (m_axis_tdata[31:16] == 16'h7FFF) || (m_axis_tdata[31:16] == 16'h8000))
        else $error("saturated status without a clamped pixel");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (.*);
